### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for concurrent checks on the decimal text core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds on every edge outside reset
`define ITDA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("itda check failed");

// check that also holds while reset is asserted
`define ITDA_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("itda check failed");

`endif

### rtl/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// shared types and character codes for the integer to decimal text core
// ----------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

   // ascii codes, six bits wide
   localparam logic [5:0] CODE_MINUS = 6'd45;
   localparam logic [5:0] CODE_ZERO  = 6'd48;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // back end sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_FIND,
      ST_SIGN,
      ST_DIGIT
   } back_state_type;

endpackage

`default_nettype wire

### rtl/itda_front.sv
// ----------------------------------------------------------------------------
// itda_front
// input stage: takes a value, splits it into sign and unsigned magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module itda_front import itda_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   input  wire q_stat_type             q_stat,
   output      logic                   q_push,
   output      logic                   q_neg,
   output      logic [VALUE_WIDTH-1:0] q_mag
);

   logic                   valid_ff, valid_in;
   logic                   neg_ff;
   logic [VALUE_WIDTH-1:0] mag_ff;
   logic                   take;
   logic                   sign_bit;

   // stage is free when empty or draining into the queue this cycle
   assign req_ready = !valid_ff || !q_stat.full;
   assign take      = req_valid && req_ready;
   assign sign_bit  = req_value[VALUE_WIDTH-1];

   assign q_push = valid_ff;
   assign q_neg  = neg_ff;
   assign q_mag  = mag_ff;

   // occupancy of the classify stage
   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (!q_stat.full) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // magnitude as unsigned, most negative value wraps to 2^(w-1)
   always_ff @(posedge clock) begin
      if (take) begin
         neg_ff <= sign_bit;
         mag_ff <= sign_bit ? (~req_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : req_value;
      end
   end

endmodule

`default_nettype wire

### rtl/itda_queue.sv
// ----------------------------------------------------------------------------
// itda_queue
// two entry queue between the classify stage and the converter
// ----------------------------------------------------------------------------
`default_nettype none

module itda_queue import itda_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic                   push_neg,
   input  wire logic [VALUE_WIDTH-1:0] push_mag,
   input  wire logic                   pop,
   output      logic                   pop_neg,
   output      logic [VALUE_WIDTH-1:0] pop_mag,
   output      q_stat_type             stat
);

   logic                   neg_mem [2];
   logic [VALUE_WIDTH-1:0] mag_mem [2];
   logic                   wr_ptr_ff, rd_ptr_ff;
   logic [1:0]             count_ff, count_in;
   logic                   do_push, do_pop;

   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;

   assign pop_neg = neg_mem[rd_ptr_ff];
   assign pop_mag = mag_mem[rd_ptr_ff];

   // fill level
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         neg_mem[wr_ptr_ff] <= push_neg;
         mag_mem[wr_ptr_ff] <= push_mag;
      end
   end

endmodule

`default_nettype wire

### rtl/itda_back.sv
// ----------------------------------------------------------------------------
// itda_back
// converter: bit-serial binary to bcd, then emits characters msd first
// ----------------------------------------------------------------------------
`default_nettype none

module itda_back import itda_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire q_stat_type             q_stat,
   input  wire logic                   q_neg,
   input  wire logic [VALUE_WIDTH-1:0] q_mag,
   output      logic                   q_pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [5:0]             rsp_char_code,
   output      logic                   rsp_last_char
);

   // decimal digits needed for a VALUE_WIDTH bit magnitude
   localparam int NDIG  = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int BCD_W = 4 * NDIG;
   localparam int POS_W = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   back_state_type         state_ff, state_in;
   logic [VALUE_WIDTH-1:0] sh_ff, sh_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in, adj;
   logic [CNT_W-1:0]       bit_cnt_ff;
   logic [POS_W-1:0]       pos_ff, msd;
   logic                   neg_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [5:0]             code_ff;
   logic                   last_ff;
   logic                   out_free;
   logic [3:0]             cur_digit;
   logic                   load, step, find, emit_sign, emit_digit;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = code_ff;
   assign rsp_last_char = last_ff;
   assign cur_digit     = bcd_ff[4*pos_ff +: 4];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (bit_cnt_ff == CNT_W'(1)) state_in = ST_FIND;
         end
         ST_FIND: begin
            state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (out_free && (pos_ff == '0)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      load       = 1'b0;
      step       = 1'b0;
      find       = 1'b0;
      emit_sign  = 1'b0;
      emit_digit = 1'b0;
      unique case (state_ff)
         ST_IDLE:  load       = !q_stat.empty;
         ST_CONV:  step       = 1'b1;
         ST_FIND:  find       = 1'b1;
         ST_SIGN:  emit_sign  = out_free;
         ST_DIGIT: emit_digit = out_free;
         default: begin
         end
      endcase
   end

   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // add 3 to every digit of 5 or more, then shift one magnitude bit in
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? (bcd_ff[4*i +: 4] + 4'd3)
                                                    : bcd_ff[4*i +: 4];
      end
      bcd_in = {adj[BCD_W-2:0], sh_ff[VALUE_WIDTH-1]};
      sh_in  = {sh_ff[VALUE_WIDTH-2:0], 1'b0};
   end

   // most significant nonzero digit, zero gives position 0
   always_comb begin
      msd = '0;
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) msd = POS_W'(i);
      end
   end

   // conversion datapath
   always_ff @(posedge clock) begin
      if (load) begin
         sh_ff      <= q_mag;
         neg_ff     <= q_neg;
         bcd_ff     <= '0;
         bit_cnt_ff <= CNT_W'(VALUE_WIDTH);
      end else if (step) begin
         sh_ff      <= sh_in;
         bcd_ff     <= bcd_in;
         bit_cnt_ff <= bit_cnt_ff - CNT_W'(1);
      end
      if (find) begin
         pos_ff <= msd;
      end else if (emit_digit && (pos_ff != '0)) begin
         pos_ff <= pos_ff - POS_W'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_sign || emit_digit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_sign) begin
         code_ff <= CODE_MINUS;
         last_ff <= 1'b0;
      end else if (emit_digit) begin
         code_ff <= CODE_ZERO + {2'b00, cur_digit};
         last_ff <= (pos_ff == '0);
      end
   end

endmodule

`default_nettype wire

### rtl/int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// signed integer in, decimal ascii text out one character per transfer
//
//   channel  ports                          payload
//   req      req_valid / req_ready          req_value (VALUE_WIDTH, signed)
//   rsp      rsp_valid / rsp_ready          rsp_char_code (6), rsp_last_char
//
// the converter loads a value, runs it through the bit-serial bcd shifter,
// one shift per cycle, finds the leading digit and then sends its
// characters (1 to 11 at 32 bits).
// the classify stage and a two entry queue take up to three more values
// while the converter works, so req_ready drops only when all are full.
// reset is synchronous and clears all handshake and sequencer state.
// rsp stalls hold the character register; the converter waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii_core import itda_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [5:0]             rsp_char_code,
   output      logic                   rsp_last_char
);

   q_stat_type             q_stat;
   logic                   push, push_neg, pop, pop_neg;
   logic [VALUE_WIDTH-1:0] push_mag, pop_mag;

   // sign and magnitude split
   itda_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .q_stat    (q_stat),
      .q_push    (push),
      .q_neg     (push_neg),
      .q_mag     (push_mag)
   );

   // decoupling queue
   itda_queue #(.VALUE_WIDTH(VALUE_WIDTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_neg (push_neg),
      .push_mag (push_mag),
      .pop      (pop),
      .pop_neg  (pop_neg),
      .pop_mag  (pop_mag),
      .stat     (q_stat)
   );

   // conversion and character output
   itda_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_neg         (pop_neg),
      .q_mag         (pop_mag),
      .q_pop         (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

`default_nettype wire

### rtl/itda_checker.sv
// ----------------------------------------------------------------------------
// itda_checker
// port level checks on the character stream of the decimal text core
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module itda_checker import itda_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [5:0] rsp_char_code,
   input wire logic       rsp_last_char
);

   logic       rsp_stall;
   logic [6:0] rsp_payload;
   logic       is_minus;
   logic       legal_code;

   // character transfer state seen at the port
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_char_code, rsp_last_char};
   assign is_minus    = (rsp_char_code == CODE_MINUS);
   assign legal_code  = is_minus ||
                        ((rsp_char_code >= CODE_ZERO) &&
                         (rsp_char_code <= CODE_ZERO + 6'd9));

   // nothing leaves in the cycle after reset
   `ITDA_ASSERT_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_valid)

   // a stalled character holds its payload
   `ITDA_ASSERT(a_hold_on_stall, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // only the minus sign or a decimal digit is ever sent
   `ITDA_ASSERT(a_legal_code, clock, reset, rsp_valid |-> legal_code)

   // the sign is always followed by at least one digit
   `ITDA_ASSERT(a_sign_not_last, clock, reset, rsp_valid && is_minus |-> !rsp_last_char)

endmodule

bind int_to_decimal_ascii_core itda_checker u_itda_checker (.*);

`default_nettype wire

### sim/decimal_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_checker
// watches both channels of the integer to decimal text core, works out the
// characters each accepted value must produce and compares every character
// transfer against the oldest one still outstanding
// ----------------------------------------------------------------------------

module decimal_text_checker import itda_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [5:0]  rsp_char_code,
   input  logic        rsp_last_char,
   output int          error_count,
   output int          chars_pending
);

   typedef struct packed {
      logic [5:0] code;
      logic       last;
   } text_char_type;

   text_char_type expected_chars[$];

   initial begin
      error_count   = 0;
      chars_pending = 0;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // sign, then digits most significant first, last flag on the final digit
   function automatic void push_decimal_text(input logic [31:0] value);
      logic [31:0] magnitude;
      logic [3:0]  digits [0:10];
      int          num_digits;
      int          i;
      magnitude  = value[31] ? -value : value;
      num_digits = 0;
      do begin
         digits[num_digits] = 4'(magnitude % 10);
         num_digits++;
         magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (value[31]) begin
         expected_chars.push_back('{code: CODE_MINUS, last: 1'b0});
      end
      for (i = num_digits - 1; i >= 0; i--) begin
         expected_chars.push_back('{code: CODE_ZERO + 6'(digits[i]), last: (i == 0)});
      end
   endfunction

   // predict on each value transfer, compare on each character transfer
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            push_decimal_text(req_value);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character code %0d last %0d",
                                         rsp_char_code, rsp_last_char));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_char_code !== want.code) begin
                  report_mismatch($sformatf("char_code %0d, expected %0d",
                                            rsp_char_code, want.code));
               end
               if (rsp_last_char !== want.last) begin
                  report_mismatch($sformatf("last_char %0d, expected %0d",
                                            rsp_last_char, want.last));
               end
            end
         end
      end
      chars_pending = expected_chars.size();
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives signed values into the integer to decimal text core: a directed set
// of edge values, a back-pressure burst, then random values under three idle
// mixes; a separate checker predicts and compares the character stream
// ----------------------------------------------------------------------------

module testbench;

   localparam int VALUE_WIDTH = 32;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 60;
   localparam int HOLD_LEN    = 300;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [5:0]             rsp_char_code;
   logic                   rsp_last_char;

   int error_count;
   int chars_pending;
   int tx_idle_pct;
   int rx_idle_pct;
   int rx_hold_cycles;
   int stall_cycles;

   int_to_decimal_ascii_core #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last_char(rsp_last_char)
   );

   decimal_text_checker u_text_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last_char(rsp_last_char),
      .error_count  (error_count),
      .chars_pending(chars_pending)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // character sink: long hold-off when requested, else random stalls
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rx_hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // ends the run if no transfer happens on either channel for too long
   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   // offer one value, with random idle cycles in front; returns at a falling edge
   task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // stimulus and verdict
   initial begin
      logic [VALUE_WIDTH-1:0] directed [$];
      logic [VALUE_WIDTH-1:0] v;
      logic [VALUE_WIDTH-1:0] p10;
      int                     phase;
      int                     n;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_value      = '0;
      tx_idle_pct    = 0;
      rx_idle_pct    = 0;
      rx_hold_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero, single digits, carries across digit counts, both extremes
      directed = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                   -32'sd9, 32'd999999999, 32'd1000000000, -32'sd1000000000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555,
                   32'hAAAA_AAAA};
      tx_idle_pct = 12;
      rx_idle_pct = 47;
      foreach (directed[i]) send_value(directed[i]);

      // sink holds off while values keep coming, so the input side fills up
      rx_hold_cycles = HOLD_LEN;
      tx_idle_pct    = 0;
      for (n = 0; n < 10; n++) send_value($urandom);
      req_valid <= 1'b0;
      while (chars_pending != 0) @(negedge clock);

      // random values under three idle mixes, draining between phases
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 12; rx_idle_pct = 47; end
            1: begin tx_idle_pct = 47; rx_idle_pct = 12; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         for (n = 0; n < 35; n++) begin
            case ($urandom_range(3))
               0: v = $urandom;
               1: v = $urandom_range(999);
               // powers of ten and one below them
               2: begin
                  p10 = 1;
                  repeat ($urandom_range(9)) p10 = p10 * 10;
                  v = p10 - $urandom_range(1);
               end
               // near the most negative value and the most positive one
               default: v = 32'h8000_0000 - $urandom_range(3);
            endcase
            if ($urandom_range(1)) v = -v;
            send_value(v);
         end
         req_valid <= 1'b0;
         while (chars_pending != 0) @(negedge clock);
      end

      repeat (DRAIN_WAIT) @(negedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
